// ----- rtl/core/pzz_pkg.sv -----
`default_nettype none
package pzz_pkg;

  localparam int CW   = 24;
  localparam int ZW   = 25;
  localparam int DEPW = 23;
  localparam int RADW = 23;
  localparam int CFGW = 20;
  localparam int STW  = 3;
  localparam int IXW  = 2;

  localparam logic [STW-1:0] ST_OK        = 3'd0;
  localparam logic [STW-1:0] ST_BAD_SHAPE = 3'd1;
  localparam logic [STW-1:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [STW-1:0] ST_NO_FIT    = 3'd3;
  localparam logic [STW-1:0] ST_NO_PASSES = 3'd4;
  localparam logic [STW-1:0] ST_TOO_MANY  = 3'd5;

  localparam logic [IXW-1:0] CFG_TOOL  = 2'd0;
  localparam logic [IXW-1:0] CFG_STEP  = 2'd1;
  localparam logic [IXW-1:0] CFG_STOCK = 2'd2;

  localparam logic [1:0] SHAPE_RECT = 2'd0;
  localparam logic [1:0] SHAPE_CIRC = 2'd1;

  localparam logic [CFGW-1:0] TOOL_RST  = 20'd1000;
  localparam logic [CFGW-1:0] STEP_RST  = 20'd500;
  localparam logic [CFGW-1:0] STOCK_RST = 20'd0;

  typedef enum logic [1:0] {
    DSEL_PASS = 2'd0,
    DSEL_Y    = 2'd1,
    DSEL_H    = 2'd2
  } div_sel_t;

  typedef enum logic [1:0] {
    MSEL_NUM = 2'd0,
    MSEL_A   = 2'd1,
    MSEL_ASQ = 2'd2,
    MSEL_BSQ = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic           in_ready;
    logic           load;
    logic           check;
    logic           div_start;
    div_sel_t       div_sel;
    logic           mul_en;
    mul_sel_t       mul_sel;
    logic           pset;
    logic           num_take;
    logic           y_take;
    logic           asq_take;
    logic           sqrt_start;
    logic           h_rect_take;
    logic           h_div_take;
    logic           pend_take;
    logic           i_clr;
    logic           i_inc;
    logic           out_load;
    logic           out_pend;
    logic           out_last;
    logic [STW-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic           in_valid;
    logic [STW-1:0] chk_code;
    logic           too_many;
    logic           div_done;
    logic           sqrt_done;
    logic           is_rect;
    logic           h_zero;
    logic           i_last;
    logic           out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/pzz_ifs.sv -----
`default_nettype none
interface pzz_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          pocket_shape;
  logic signed [pzz_pkg::CW-1:0]       center_x;
  logic signed [pzz_pkg::CW-1:0]       center_y;
  logic signed [pzz_pkg::CW-1:0]       top_z;
  logic [pzz_pkg::CW-1:0]              pocket_length;
  logic [pzz_pkg::CW-1:0]              pocket_width;
  logic [pzz_pkg::RADW-1:0]            pocket_radius;
  logic [pzz_pkg::DEPW-1:0]            pocket_depth;
  modport source (output valid, pocket_shape, center_x, center_y, top_z, pocket_length,
                  pocket_width, pocket_radius, pocket_depth, input ready);
  modport sink (input valid, pocket_shape, center_x, center_y, top_z, pocket_length,
                pocket_width, pocket_radius, pocket_depth, output ready);
endinterface

interface pzz_out_if;
  logic                          valid;
  logic                          ready;
  logic [pzz_pkg::STW-1:0]       status;
  logic signed [pzz_pkg::CW-1:0] pass_y;
  logic signed [pzz_pkg::CW-1:0] x_start;
  logic signed [pzz_pkg::CW-1:0] x_end;
  logic signed [pzz_pkg::ZW-1:0] cut_z;
  logic                          last_pass;
  modport source (output valid, status, pass_y, x_start, x_end, cut_z, last_pass,
                  input ready);
  modport sink (input valid, status, pass_y, x_start, x_end, cut_z, last_pass,
                output ready);
endinterface

interface pzz_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pzz_pkg::IXW-1:0]    index;
  logic [pzz_pkg::CFGW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pzz_div.sv -----
`default_nettype none
module pzz_div #(
  parameter int NW = 31,
  parameter int DW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     sh;
  logic            take;

  assign sh   = {rem, quo[NW-1]};
  assign take = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNTW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (take) begin
        rem <= DW'(sh - {1'b0, dvs});
      end else begin
        rem <= sh[DW-1:0];
      end
      quo <= {quo[NW-2:0], take};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pzz_isqrt.sv -----
`default_nettype none
module pzz_isqrt #(
  parameter int RW = 31
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [2*RW-1:0] operand,
  output logic                 done,
  output logic [RW-1:0]        root
);

  localparam int CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] op;
  logic [RW+1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [RW+3:0]   sh;
  logic [RW+3:0]   trial;
  logic            take;

  assign sh    = {rem, op[2*RW-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign take  = sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNTW'(RW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      if (take) begin
        rem <= (RW+2)'(sh - trial);
      end else begin
        rem <= sh[RW+1:0];
      end
      root <= {root[RW-2:0], take};
      op   <= {op[2*RW-3:0], 2'b00};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pzz_ctrl.sv -----
`default_nettype none
module pzz_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pzz_pkg::sts_t sts,
  output pzz_pkg::cmd_t      cmd
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CHECK = 17'h00002,
    S_PWAIT = 17'h00004,
    S_MNUM  = 17'h00008,
    S_YST   = 17'h00010,
    S_YWT   = 17'h00020,
    S_MA    = 17'h00040,
    S_MASQ  = 17'h00080,
    S_MBSQ  = 17'h00100,
    S_SQST  = 17'h00200,
    S_SQWT  = 17'h00400,
    S_HST   = 17'h00800,
    S_HWT   = 17'h01000,
    S_DEC   = 17'h02000,
    S_FIN   = 17'h04000,
    S_ERR   = 17'h08000,
    S_SPARE = 17'h10000
  } state_t;

  state_t                  state, state_next;
  logic [pzz_pkg::STW-1:0] code, code_next;
  logic                    has_pend, has_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      code     <= pzz_pkg::ST_OK;
      has_pend <= 1'b0;
    end else begin
      state    <= state_next;
      code     <= code_next;
      has_pend <= has_pend_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    code_next     = code;
    has_pend_next = has_pend;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.chk_code != pzz_pkg::ST_OK) begin
          code_next  = sts.chk_code;
          state_next = S_ERR;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = pzz_pkg::DSEL_PASS;
          state_next    = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (sts.div_done) begin
          if (sts.too_many) begin
            code_next  = pzz_pkg::ST_TOO_MANY;
            state_next = S_ERR;
          end else begin
            cmd.pset      = 1'b1;
            cmd.i_clr     = 1'b1;
            has_pend_next = 1'b0;
            state_next    = S_MNUM;
          end
        end
      end
      S_MNUM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pzz_pkg::MSEL_NUM;
        state_next  = S_YST;
      end
      S_YST: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pzz_pkg::DSEL_Y;
        cmd.num_take  = 1'b1;
        state_next    = S_YWT;
      end
      S_YWT: begin
        if (sts.div_done) begin
          cmd.y_take = 1'b1;
          if (sts.is_rect) begin
            cmd.h_rect_take = 1'b1;
            state_next      = S_DEC;
          end else begin
            state_next = S_MA;
          end
        end
      end
      S_MA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pzz_pkg::MSEL_A;
        state_next  = S_MASQ;
      end
      S_MASQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pzz_pkg::MSEL_ASQ;
        state_next  = S_MBSQ;
      end
      S_MBSQ: begin
        cmd.asq_take = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = pzz_pkg::MSEL_BSQ;
        state_next   = S_SQST;
      end
      S_SQST: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQWT;
      end
      S_SQWT: begin
        if (sts.sqrt_done) begin
          state_next = S_HST;
        end
      end
      S_HST: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pzz_pkg::DSEL_H;
        state_next    = S_HWT;
      end
      S_HWT: begin
        if (sts.div_done) begin
          cmd.h_div_take = 1'b1;
          state_next     = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.h_zero || !has_pend || sts.out_free) begin
          if (!sts.h_zero) begin
            cmd.pend_take = 1'b1;
            has_pend_next = 1'b1;
            if (has_pend) begin
              cmd.out_load = 1'b1;
              cmd.out_pend = 1'b1;
            end
          end
          if (sts.i_last) begin
            state_next = S_FIN;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = S_MNUM;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_pend = has_pend;
          cmd.out_last = 1'b1;
          cmd.code     = pzz_pkg::ST_NO_PASSES;
          state_next   = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.code     = code;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/pzz_datapath.sv -----
`default_nettype none
module pzz_datapath #(
  parameter int MAX_PASSES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pzz_pkg::cmd_t cmd,
  output pzz_pkg::sts_t      sts,
  pzz_in_if.sink             in_ch,
  pzz_out_if.source          out_ch,
  pzz_cfg_if.sink            cfg
);

  localparam int IW   = $clog2(MAX_PASSES);
  localparam int AW   = 25 + IW;
  localparam int CW   = pzz_pkg::CW;
  localparam int CFGW = pzz_pkg::CFGW;

  logic [CFGW-1:0] tool, step, stock;

  always_ff @(posedge clk) begin
    if (rst) begin
      tool  <= pzz_pkg::TOOL_RST;
      step  <= pzz_pkg::STEP_RST;
      stock <= pzz_pkg::STOCK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pzz_pkg::CFG_TOOL:  tool  <= cfg.data;
        pzz_pkg::CFG_STEP:  step  <= cfg.data;
        pzz_pkg::CFG_STOCK: stock <= cfg.data;
        default: ;
      endcase
    end
  end
  assign cfg.ready = 1'b1;

  logic [1:0]                   shape;
  logic signed [CW-1:0]         cx, cy, tz;
  logic [CW-1:0]                len, wid;
  logic [pzz_pkg::RADW-1:0]     rad;
  logic [pzz_pkg::DEPW-1:0]     dep;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shape <= in_ch.pocket_shape;
      cx    <= in_ch.center_x;
      cy    <= in_ch.center_y;
      tz    <= in_ch.top_z;
      len   <= in_ch.pocket_length;
      wid   <= in_ch.pocket_width;
      rad   <= in_ch.pocket_radius;
      dep   <= in_ch.pocket_depth;
    end
  end
  assign in_ch.ready = cmd.in_ready;

  logic signed [25:0]       two_s, d26, x2, span_r, span_c, span;
  logic                     is_rect;
  logic [pzz_pkg::STW-1:0]  chk_code;
  logic signed [25:0]       cutz_w;

  assign is_rect = shape == pzz_pkg::SHAPE_RECT;
  assign two_s   = $signed({5'b0, stock, 1'b0});
  assign d26     = $signed({6'b0, tool});
  assign x2      = $signed({2'b0, len}) - d26 - two_s;
  assign span_r  = $signed({2'b0, wid}) - d26 - two_s;
  assign span_c  = $signed({2'b0, rad, 1'b0}) - d26 - two_s;
  assign span    = is_rect ? span_r : span_c;
  assign cutz_w  = $signed({tz[CW-1], tz[CW-1], tz}) - $signed({3'b0, dep})
                   + $signed({6'b0, stock});

  always_comb begin
    if (shape != pzz_pkg::SHAPE_RECT && shape != pzz_pkg::SHAPE_CIRC) begin
      chk_code = pzz_pkg::ST_BAD_SHAPE;
    end else if (tool == '0 || dep == '0 || step == '0) begin
      chk_code = pzz_pkg::ST_ZERO_SIZE;
    end else if (span <= 26'sd0 || (is_rect && x2 <= 26'sd0)) begin
      chk_code = pzz_pkg::ST_NO_FIT;
    end else begin
      chk_code = pzz_pkg::ST_OK;
    end
  end

  logic [CW-1:0]   span2;
  logic [CW-2:0]   hrect;
  logic [IW-1:0]   pm1, idx;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      span2 <= span[CW-1:0];
      hrect <= x2[CW-1:1];
    end
  end

  logic          div_done;
  logic [AW-1:0] div_a, quo;
  logic [19:0]   div_b, rem;
  logic [2*AW-1:0] prod, asq;
  logic [AW-1:0]   root;

  always_comb begin
    case (cmd.div_sel)
      pzz_pkg::DSEL_Y: begin
        div_a = prod[AW-1:0];
        div_b = 20'({pm1, 1'b0});
      end
      pzz_pkg::DSEL_H: begin
        div_a = root;
        div_b = 20'({pm1, 2'b00});
      end
      default: begin
        div_a = AW'(span[CW-1:0]) + AW'(step) - AW'(1);
        div_b = step;
      end
    endcase
  end

  pzz_div #(.NW(AW), .DW(20)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.pset) begin
      pm1 <= quo[IW-1:0];
    end
    if (cmd.i_clr) begin
      idx <= '0;
    end else if (cmd.i_inc) begin
      idx <= idx + 1'b1;
    end
  end

  logic signed [IW+1:0] tt;
  logic [IW+1:0]        tmag;
  logic [AW-1:0]        op_a, op_b, num_mag;
  logic                 num_neg;

  assign tt   = $signed({1'b0, idx, 1'b0}) - $signed({2'b0, pm1});
  assign tmag = tt[IW+1] ? (IW+2)'(-tt) : tt;

  always_comb begin
    case (cmd.mul_sel)
      pzz_pkg::MSEL_NUM: begin
        op_a = AW'(span2);
        op_b = AW'(tmag);
      end
      pzz_pkg::MSEL_A: begin
        op_a = AW'(span2);
        op_b = AW'({pm1, 1'b0});
      end
      pzz_pkg::MSEL_ASQ: begin
        op_a = prod[AW-1:0];
        op_b = prod[AW-1:0];
      end
      default: begin
        op_a = {num_mag[AW-2:0], 1'b0};
        op_b = {num_mag[AW-2:0], 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    if (cmd.mul_en && cmd.mul_sel == pzz_pkg::MSEL_NUM) begin
      num_neg <= tt[IW+1];
    end
    if (cmd.num_take) begin
      num_mag <= prod[AW-1:0];
    end
    if (cmd.asq_take) begin
      asq <= prod;
    end
  end

  logic          sqrt_done;

  pzz_isqrt #(.RW(AW)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.sqrt_start),
    .operand (asq - prod),
    .done    (sqrt_done),
    .root    (root)
  );

  logic [CW-1:0] qq, yoff, y_r, h;
  logic [CW-1:0] pend_y, pend_xs, pend_xe;
  logic          fwd;

  assign qq   = quo[CW-1:0];
  assign yoff = num_neg ? (~qq + CW'(1) - CW'(rem != '0)) : qq;

  always_ff @(posedge clk) begin
    if (cmd.y_take) begin
      y_r <= CW'(cy) + yoff;
    end
    if (cmd.h_rect_take) begin
      h <= {1'b0, hrect};
    end else if (cmd.h_div_take) begin
      h <= quo[CW-1:0];
    end
    if (cmd.pend_take) begin
      pend_y  <= y_r;
      pend_xs <= fwd ? CW'(cx) - h : CW'(cx) + h;
      pend_xe <= fwd ? CW'(cx) + h : CW'(cx) - h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      fwd <= 1'b1;
    end else if (cmd.pend_take) begin
      fwd <= !fwd;
    end
  end

  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.last_pass <= cmd.out_last;
      if (cmd.out_pend) begin
        out_ch.status  <= pzz_pkg::ST_OK;
        out_ch.pass_y  <= pend_y;
        out_ch.x_start <= pend_xs;
        out_ch.x_end   <= pend_xe;
        out_ch.cut_z   <= cutz_w[pzz_pkg::ZW-1:0];
      end else begin
        out_ch.status  <= cmd.code;
        out_ch.pass_y  <= '0;
        out_ch.x_start <= '0;
        out_ch.x_end   <= '0;
        out_ch.cut_z   <= '0;
      end
    end
  end
  assign out_ch.valid = out_valid;

  assign sts.in_valid  = in_ch.valid;
  assign sts.chk_code  = chk_code;
  assign sts.too_many  = quo > AW'(MAX_PASSES - 1);
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.is_rect   = is_rect;
  assign sts.h_zero    = h == '0;
  assign sts.i_last    = idx == pm1;
  assign sts.out_free  = !out_valid || out_ch.ready;

endmodule
`default_nettype wire

// ----- rtl/core/pocket_zigzag_pass_planner_top.sv -----
// zigzag floor pass planner for one rectangular or circular pocket
// in_ch carries one pocket description a word; out_ch returns one word per
// floor pass (status ok) or a single status word on error; last_pass marks
// the final word for each pocket. cfg writes tool diameter (0), stepover (1)
// and stock to leave (2), taken every cycle; the user must write cfg only
// while the block is idle, which the block itself does not enforce. a pocket
// is taken only when the planner is idle; the pass count comes from a
// restoring divider of width W = 25 + clog2(MAX_PASSES). each rectangle pass
// needs one multiplier product and one divider run for pass y. each circle
// pass needs a divider run for pass y, a shared multiplier for four products,
// a bit-per-cycle square root and a second divider run for the half width.
// passes are held one deep so the last one can be flagged, then moved into
// a single output register; when the receiver stalls the planner waits on
// that register and no word is dropped.
// reset restores the default tool settings and empties the output register.
`default_nettype none
module pocket_zigzag_pass_planner_top #(
  parameter int MAX_PASSES = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  pzz_in_if.sink    in_ch,
  pzz_out_if.source out_ch,
  pzz_cfg_if.sink   cfg
);

  pzz_pkg::cmd_t cmd;
  pzz_pkg::sts_t sts;

  pzz_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  pzz_datapath #(.MAX_PASSES(MAX_PASSES)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

endmodule
`default_nettype wire

// ----- bench/pocket_zigzag_pass_planner_top_test.sv -----
`default_nettype none
module pocket_zigzag_pass_planner_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PASSES = 64;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int CW   = pzz_pkg::CW;
  localparam int ZW   = pzz_pkg::ZW;
  localparam int RADW = pzz_pkg::RADW;
  localparam int DEPW = pzz_pkg::DEPW;
  localparam int STW  = pzz_pkg::STW;
  localparam int CFGW = pzz_pkg::CFGW;
  localparam int IXW  = pzz_pkg::IXW;

  typedef struct {
    logic [1:0]      shape;
    logic [CW-1:0]   cx;
    logic [CW-1:0]   cy;
    logic [CW-1:0]   tz;
    logic [CW-1:0]   len;
    logic [CW-1:0]   wid;
    logic [RADW-1:0] rad;
    logic [DEPW-1:0] dep;
  } pocket_t;

  typedef struct {
    logic [STW-1:0] status;
    logic [CW-1:0]  y;
    logic [CW-1:0]  xs;
    logic [CW-1:0]  xe;
    logic [ZW-1:0]  z;
    logic           last;
  } pass_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pzz_in_if  in_ch ();
  pzz_out_if out_ch ();
  pzz_cfg_if cfg ();

  pocket_zigzag_pass_planner_top #(.MAX_PASSES(MAX_PASSES)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  pocket_t pocket_q[$];
  pass_t   pass_q[$];
  logic [CFGW-1:0] tool_dia = pzz_pkg::TOOL_RST;
  logic [CFGW-1:0] step_max = pzz_pkg::STEP_RST;
  logic [CFGW-1:0] stock = pzz_pkg::STOCK_RST;
  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  hold_left = 0;
  logic in_fire = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= res + b) begin
        a -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic pass_t status_word(logic [STW-1:0] code);
    pass_t r;
    r.status = code;
    r.y = '0;
    r.xs = '0;
    r.xe = '0;
    r.z = '0;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic plan_pocket(pocket_t p);
    longint cx, cy, tz, d, s, st, x2, span2, np, den, num, h, cutz, ofs;
    longint unsigned a, an, sq;
    bit rect, fwd;
    int count;
    pass_t r;
    cx = longint'(signed'(p.cx));
    cy = longint'(signed'(p.cy));
    tz = longint'(signed'(p.tz));
    d = tool_dia;
    s = stock;
    st = step_max;
    rect = (p.shape == pzz_pkg::SHAPE_RECT);
    fwd = 1;
    count = 0;
    x2 = 0;
    if (p.shape != pzz_pkg::SHAPE_RECT && p.shape != pzz_pkg::SHAPE_CIRC) begin
      pass_q.push_back(status_word(pzz_pkg::ST_BAD_SHAPE));
      return;
    end
    if (d == 0 || p.dep == 0 || st == 0) begin
      pass_q.push_back(status_word(pzz_pkg::ST_ZERO_SIZE));
      return;
    end
    if (rect) begin
      x2 = longint'(p.len) - d - 2 * s;
      span2 = longint'(p.wid) - d - 2 * s;
    end else begin
      span2 = 2 * longint'(p.rad) - d - 2 * s;
    end
    if (span2 <= 0 || (rect && x2 <= 0)) begin
      pass_q.push_back(status_word(pzz_pkg::ST_NO_FIT));
      return;
    end
    np = (span2 + st - 1) / st + 1;
    if (np > MAX_PASSES) begin
      pass_q.push_back(status_word(pzz_pkg::ST_TOO_MANY));
      return;
    end
    cutz = tz - longint'(p.dep) + s;
    den = 2 * (np - 1);
    for (longint i = 0; i < np; i++) begin
      num = span2 * (2 * i - (np - 1));
      ofs = floor_div(num, den);
      if (rect) begin
        h = x2 / 2;
      end else begin
        a = span2 * den;
        an = (num < 0) ? -num : num;
        sq = a * a - 4 * an * an;
        h = int_sqrt(sq) / (2 * den);
      end
      if (h > 0) begin
        r.status = pzz_pkg::ST_OK;
        r.y = CW'(cy + ofs);
        r.xs = CW'(fwd ? cx - h : cx + h);
        r.xe = CW'(fwd ? cx + h : cx - h);
        r.z = ZW'(cutz);
        r.last = 1'b0;
        pass_q.push_back(r);
        count++;
        fwd = !fwd;
      end
    end
    if (count == 0) pass_q.push_back(status_word(pzz_pkg::ST_NO_PASSES));
    else pass_q[pass_q.size() - 1].last = 1'b1;
  endtask

  // sender side
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pocket_q.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
        pocket_t p;
        p = pocket_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.pocket_shape <= p.shape;
        in_ch.center_x <= p.cx;
        in_ch.center_y <= p.cy;
        in_ch.top_z <= p.tz;
        in_ch.pocket_length <= p.len;
        in_ch.pocket_width <= p.wid;
        in_ch.pocket_radius <= p.rad;
        in_ch.pocket_depth <= p.dep;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      pocket_t p;
      p.shape = in_ch.pocket_shape;
      p.cx = in_ch.center_x;
      p.cy = in_ch.center_y;
      p.tz = in_ch.top_z;
      p.len = in_ch.pocket_length;
      p.wid = in_ch.pocket_width;
      p.rad = in_ch.pocket_radius;
      p.dep = in_ch.pocket_depth;
      plan_pocket(p);
    end
  end

  // receiver side, long hold counted here
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= 3000;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[pocket_zigzag_pass_planner_top] ERROR");
      $finish;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pass_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word status=%0d", out_ch.status);
      end else begin
        pass_t e;
        e = pass_q.pop_front();
        if (e.status !== out_ch.status || e.y !== out_ch.pass_y || e.xs !== out_ch.x_start
            || e.xe !== out_ch.x_end || e.z !== out_ch.cut_z
            || e.last !== out_ch.last_pass) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch exp st=%0d y=%0d xs=%0d xe=%0d z=%0d last=%0d",
                   e.status, signed'(e.y), signed'(e.xs), signed'(e.xe), signed'(e.z),
                   e.last);
            $display(" got st=%0d y=%0d xs=%0d xe=%0d z=%0d last=%0d",
                     out_ch.status, out_ch.pass_y, out_ch.x_start, out_ch.x_end,
                     out_ch.cut_z, out_ch.last_pass);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [IXW-1:0] idx, logic [CFGW-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    case (idx)
      pzz_pkg::CFG_TOOL:  tool_dia = val;
      pzz_pkg::CFG_STEP:  step_max = val;
      default:            stock = val;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (pocket_q.size() > 0 || in_ch.valid || pass_q.size() > 0);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_tool(logic [CFGW-1:0] t, logic [CFGW-1:0] sv, logic [CFGW-1:0] sk);
    settle();
    write_reg(pzz_pkg::CFG_TOOL, t);
    write_reg(pzz_pkg::CFG_STEP, sv);
    write_reg(pzz_pkg::CFG_STOCK, sk);
  endtask

  function automatic pocket_t mk(logic [1:0] sh, int cx, int cy, int tz, int len, int wid,
                                 int rad, int dep);
    pocket_t p;
    p.shape = sh;
    p.cx = CW'(cx);
    p.cy = CW'(cy);
    p.tz = CW'(tz);
    p.len = CW'(len);
    p.wid = CW'(wid);
    p.rad = RADW'(rad);
    p.dep = DEPW'(dep);
    return p;
  endfunction

  function automatic pocket_t rand_pocket();
    pocket_t p;
    int loss, span;
    p.shape = 2'($urandom_range(1));
    p.cx = CW'($urandom);
    p.cy = CW'($urandom);
    p.tz = CW'($urandom);
    p.len = CW'($urandom);
    p.wid = CW'($urandom);
    p.rad = RADW'($urandom);
    p.dep = DEPW'($urandom);
    if ($urandom_range(99) < 15) begin
      p.shape = 2'($urandom);
      return p;
    end
    loss = int'(tool_dia) + 2 * int'(stock);
    span = int'($urandom_range(1, step_max * 12));
    p.len = CW'(loss + int'($urandom_range(1, 300000)));
    p.wid = CW'(loss + span);
    p.rad = RADW'((loss + span) / 2 + 1);
    if (p.dep == 0) p.dep = 1;
    return p;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pocket_shape = '0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.top_z = '0;
    in_ch.pocket_length = '0;
    in_ch.pocket_width = '0;
    in_ch.pocket_radius = '0;
    in_ch.pocket_depth = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // defaults: directed corners
    pocket_q.push_back(mk(2'd2, 0, 0, 0, 5000, 5000, 3000, 100));
    pocket_q.push_back(mk(2'd3, 0, 0, 0, 5000, 5000, 3000, 100));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 5000, 5000, 0, 0));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 100, -200, 1000, 5000, 3000, 0, 500));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_CIRC, -300, 400, -1000, 0, 0, 2000, 500));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 1000, 3000, 0, 5));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 3000, 1000, 0, 5));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_CIRC, 0, 0, 0, 0, 0, 500, 5));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 3000, 40000, 0, 5));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_CIRC, 0, 0, 0, 0, 0, 700, 5));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 1001, 3000, 0, 5));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 8388607, 8388607, 8388607, 16777215, 32500,
                          0, 1));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, -8388608, -8388608, -8388608, 16777215,
                          32000, 0, 8388607));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_CIRC, 8388607, -8388608, 8388607, 0, 0, 16000,
                          8388607));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_CIRC, 0, 0, 0, 16777215, 16777215, 8388607, 1));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 16777215, 16777215, 8388607, 1));

    set_tool(20'd0, 20'd1048575, 20'd1048575);
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 5000, 5000, 0, 10));
    set_tool(20'd1, 20'd0, 20'd0);
    pocket_q.push_back(mk(pzz_pkg::SHAPE_CIRC, 0, 0, 0, 0, 0, 5000, 10));
    set_tool(20'd1048575, 20'd1048575, 20'd1048575);
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 16777215, 16777215, 0, 10));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_CIRC, 0, 0, 5, 0, 0, 8388607, 10));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 0, 0, 0, 3145726, 3145727, 0, 10));
    set_tool(20'd1, 20'd1, 20'd0);
    pocket_q.push_back(mk(pzz_pkg::SHAPE_CIRC, 10, 10, 0, 0, 0, 20, 3));
    pocket_q.push_back(mk(pzz_pkg::SHAPE_RECT, 10, 10, 0, 9, 70, 0, 3));

    // random phases under varied tool settings
    set_tool(20'd3000, 20'd2000, 20'd100);
    repeat (40) pocket_q.push_back(rand_pocket());
    hold_req = 1;
    set_tool(20'd6, 20'd3, 20'd1);
    calm = 1;
    repeat (40) pocket_q.push_back(rand_pocket());
    set_tool(20'd50000, 20'd40000, 20'd5000);
    calm = 0;
    repeat (40) pocket_q.push_back(rand_pocket());
    set_tool(20'd1000 + 20'($urandom_range(5000)), 20'($urandom_range(1, 9000)),
             20'($urandom_range(2000)));
    repeat (40) pocket_q.push_back(rand_pocket());

    settle();
    if (mismatches == 0 && pass_q.size() == 0) begin
      $display("[pocket_zigzag_pass_planner_top] OK");
    end else begin
      $display("[pocket_zigzag_pass_planner_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/pzz_pkg.sv
rtl/core/pzz_ifs.sv
rtl/core/pzz_div.sv
rtl/core/pzz_isqrt.sv
rtl/core/pzz_ctrl.sv
rtl/core/pzz_datapath.sv
rtl/core/pocket_zigzag_pass_planner_top.sv
bench/pocket_zigzag_pass_planner_top_test.sv
